FILE: src/vpa_pkg.sv
`timescale 1ns / 1ps
package vpa_pkg;

    localparam int GAIN_W  = 16;
    localparam int DIV_W   = 15;
    localparam int ACC_W   = 32;
    localparam int MPLR_W  = 17;
    localparam int MCNT_W  = 5;
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PID_ENABLE = 3'd0,
        CFG_GAIN_P     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_GAIN_I     = 3'd3,
        CFG_GAIN_DIV   = 3'd4,
        CFG_MAX_DRIVE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               channel;
        logic signed [31:0] encoder_count;
        logic signed [15:0] target_ticks;
    } t_in_beat;

    typedef struct packed {
        logic               out_channel;
        logic signed [15:0] drive;
        logic               clamped;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic clear;
        logic negate;
        logic dual;
    } t_mac_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: src/vpa_mul.sv
`timescale 1ns / 1ps
module vpa_mul
    import vpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mac_cmd          i_cmd,
    input  logic [MPLR_W-1:0] i_mplier,
    input  logic [GAIN_W-1:0] i_gain_a,
    input  logic [GAIN_W-1:0] i_gain_b,
    input  logic [ACC_W-1:0]  i_acc_init,
    output t_unit_stat        o_stat,
    output logic [ACC_W-1:0]  o_acc_a,
    output logic [ACC_W-1:0]  o_acc_b
);

    logic              r_busy;
    logic              r_done;
    logic [MCNT_W-1:0] r_cnt;
    logic [MPLR_W-1:0] r_sr;
    logic [ACC_W-1:0]  r_ma;
    logic [ACC_W-1:0]  r_mb;
    logic [ACC_W-1:0]  r_acc_a;
    logic [ACC_W-1:0]  r_acc_b;
    logic              r_neg;
    logic              r_dual;

    logic              w_last;
    logic              w_sub_a;
    logic [ACC_W-1:0]  w_term_a;
    logic [ACC_W-1:0]  w_term_b;
    logic [ACC_W-1:0]  n_acc_a;
    logic [ACC_W-1:0]  n_acc_b;

    // top multiplier bit carries negative weight
    assign w_last  = (r_cnt == MCNT_W'(1));
    assign w_sub_a = w_last ^ r_neg;

    always_comb begin
        w_term_a = '0;
        w_term_b = '0;
        if (r_sr[0]) begin
            w_term_a = w_sub_a ? (ACC_W'(0) - r_ma) : r_ma;
            if (r_dual) begin
                w_term_b = w_last ? (ACC_W'(0) - r_mb) : r_mb;
            end
        end
        n_acc_a = r_acc_a + w_term_a;
        n_acc_b = r_acc_b + w_term_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(MPLR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MCNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sr   <= i_mplier;
            r_ma   <= {{(ACC_W-GAIN_W){i_gain_a[GAIN_W-1]}}, i_gain_a};
            r_mb   <= {{(ACC_W-GAIN_W){i_gain_b[GAIN_W-1]}}, i_gain_b};
            r_neg  <= i_cmd.negate;
            r_dual <= i_cmd.dual;
            if (i_cmd.clear) begin
                r_acc_a <= i_acc_init;
                r_acc_b <= '0;
            end
        end else if (r_busy) begin
            r_sr    <= r_sr >> 1;
            r_ma    <= r_ma << 1;
            r_mb    <= r_mb << 1;
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

FILE: src/vpa_div.sv
`timescale 1ns / 1ps
module vpa_div
    import vpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output t_unit_stat       o_stat,
    output logic [ACC_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [ACC_W-1:0]  r_q;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic              r_neg;

    logic [DIV_W:0]    w_sh;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;

    assign w_sh   = {r_rem, r_q[ACC_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DCNT_W'(1);
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring divide on the magnitude, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1];
            r_q   <= i_num[ACC_W-1] ? (ACC_W'(0) - i_num) : i_num;
            r_rem <= '0;
            r_den <= (i_den == '0) ? DIV_W'(1) : i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_sh[DIV_W-1:0];
            r_q   <= {r_q[ACC_W-2:0], w_ge};
        end
    end

    assign o_quot = r_neg ? (ACC_W'(0) - r_q) : r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: src/velocity_pid_antiwindup.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                 | Payload
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_beat)
// cfg      | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// An enabled beat runs two bit-serial multiply passes and a restoring divide before it raises
// o_out_valid; the next beat can be taken in the cycle in which o_out_valid rises. A
// disabled or out-of-range beat goes from the prep state straight to the finish state.
// Active-low synchronous reset clears o_out_valid and per-channel state, presets the config.
// One beat is in work at a time; a held result stalls only the final write-out.
module velocity_pid_antiwindup
    import vpa_pkg::*;
#(
    parameter int CHANNELS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PREP   = 7'b0000010,
        ST_MULERR = 7'b0000100,
        ST_MULDV  = 7'b0001000,
        ST_DIVIDE = 7'b0010000,
        ST_SETTLE = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    t_state r_state;

    logic              r_pid_en;
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_d;
    logic [GAIN_W-1:0] r_gain_i;
    logic [DIV_W-1:0]  r_gain_div;
    logic [DIV_W-1:0]  r_max_drive;

    logic [31:0]       r_last_count [CHANNELS];
    logic [15:0]       r_last_vel   [CHANNELS];
    logic [ACC_W-1:0]  r_integral   [CHANNELS];
    logic [15:0]       r_drive      [CHANNELS];

    logic              r_ch;
    logic [31:0]       r_enc;
    logic [15:0]       r_target;
    logic [15:0]       r_vel;
    logic [MPLR_W-1:0] r_dvel;
    logic [ACC_W-1:0]  r_next;
    logic [15:0]       r_res_drive;
    logic              r_res_clamp;
    logic              r_out_valid;
    t_out_beat         r_out_data;

    logic              w_in_range;
    logic [CH_W-1:0]   w_idx;
    logic [15:0]       w_vel;
    logic [MPLR_W-1:0] w_err;
    logic [MPLR_W-1:0] w_dvel;
    logic [ACC_W-1:0]  w_max;
    logic [ACC_W-1:0]  w_nmax;
    logic              w_hi;
    logic              w_lo;
    logic              w_out_free;

    t_mac_cmd          w_mac_cmd;
    logic [MPLR_W-1:0] w_mplier;
    logic [GAIN_W-1:0] w_gain_a;
    t_unit_stat        w_mac_stat;
    logic [ACC_W-1:0]  w_acc_a;
    logic [ACC_W-1:0]  w_acc_b;
    logic              w_div_start;
    t_unit_stat        w_div_stat;
    logic [ACC_W-1:0]  w_quot;

    assign w_in_range = (CH_W'(r_ch) < CHANNELS) && (32'(r_ch) < CHANNELS);
    assign w_idx      = w_in_range ? CH_W'(r_ch) : '0;

    assign w_vel  = r_enc[15:0] - r_last_count[w_idx][15:0];
    assign w_err  = {r_target[15], r_target} - {w_vel[15], w_vel};
    assign w_dvel = {w_vel[15], w_vel} - {r_last_vel[w_idx][15], r_last_vel[w_idx]};

    assign w_max  = {{(ACC_W-DIV_W){1'b0}}, r_max_drive};
    assign w_nmax = ACC_W'(0) - w_max;
    assign w_hi   = ($signed(r_next) >= $signed(w_max));
    assign w_lo   = ($signed(r_next) <= $signed(w_nmax));

    assign w_out_free = !r_out_valid || i_out_ready;

    // first pass runs on the error and builds both the sum and the integral step
    always_comb begin
        w_mac_cmd   = '0;
        w_mplier    = w_err;
        w_gain_a    = r_gain_p;
        w_div_start = 1'b0;
        case (r_state)
            ST_PREP: begin
                if (w_in_range && r_pid_en) begin
                    w_mac_cmd.start = 1'b1;
                    w_mac_cmd.clear = 1'b1;
                    w_mac_cmd.dual  = 1'b1;
                end
            end
            ST_MULERR: begin
                w_mplier = r_dvel;
                w_gain_a = r_gain_d;
                if (w_mac_stat.done) begin
                    w_mac_cmd.start  = 1'b1;
                    w_mac_cmd.negate = 1'b1;
                end
            end
            ST_MULDV: begin
                w_div_start = w_mac_stat.done;
            end
            default: begin
            end
        endcase
    end

    vpa_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_mac_cmd),
        .i_mplier   (w_mplier),
        .i_gain_a   (w_gain_a),
        .i_gain_b   (r_gain_i),
        .i_acc_init (r_integral[w_idx]),
        .o_stat     (w_mac_stat),
        .o_acc_a    (w_acc_a),
        .o_acc_b    (w_acc_b)
    );

    vpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc_a),
        .i_den   (r_gain_div),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid_en    <= 1'b0;
            r_gain_p    <= GAIN_W'(20);
            r_gain_d    <= GAIN_W'(12);
            r_gain_i    <= '0;
            r_gain_div  <= DIV_W'(50);
            r_max_drive <= DIV_W'(255);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PID_ENABLE: r_pid_en    <= i_cfg_data[0];
                CFG_GAIN_P:     r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_DIV:   r_gain_div  <= i_cfg_data[DIV_W-1:0];
                CFG_MAX_DRIVE:  r_max_drive <= i_cfg_data[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_last_count[c] <= '0;
                r_last_vel[c]   <= '0;
                r_integral[c]   <= '0;
                r_drive[c]      <= '0;
            end
        end else begin
            // drop valid once the beat is taken; the finish state reloads it itself
            if (r_out_valid && i_out_ready && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (w_in_range && r_pid_en) begin
                        r_state <= ST_MULERR;
                    end else begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_MULERR: begin
                    if (w_mac_stat.done) begin
                        r_state <= ST_MULDV;
                    end
                end
                ST_MULDV: begin
                    if (w_mac_stat.done) begin
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_SETTLE;
                    end
                end
                ST_SETTLE: begin
                    r_last_count[w_idx] <= r_enc;
                    r_last_vel[w_idx]   <= r_vel;
                    if (w_hi) begin
                        r_drive[w_idx] <= w_max[15:0];
                    end else if (w_lo) begin
                        r_drive[w_idx] <= w_nmax[15:0];
                    end else begin
                        r_drive[w_idx]    <= r_next[15:0];
                        r_integral[w_idx] <= r_integral[w_idx] + w_acc_b;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold here while the previous result is still unclaimed
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_ch     <= i_in_data.channel;
                    r_enc    <= i_in_data.encoder_count;
                    r_target <= i_in_data.target_ticks;
                end
            end
            ST_PREP: begin
                r_vel       <= w_vel;
                r_dvel      <= w_dvel;
                r_res_clamp <= 1'b0;
                r_res_drive <= w_in_range ? r_drive[w_idx] : 16'd0;
            end
            ST_DIVIDE: begin
                if (w_div_stat.done) begin
                    r_next <= w_quot + {{(ACC_W-16){r_drive[w_idx][15]}}, r_drive[w_idx]};
                end
            end
            ST_SETTLE: begin
                r_res_clamp <= w_hi || w_lo;
                if (w_hi) begin
                    r_res_drive <= w_max[15:0];
                end else if (w_lo) begin
                    r_res_drive <= w_nmax[15:0];
                end else begin
                    r_res_drive <= r_next[15:0];
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    r_out_data.out_channel <= r_ch;
                    r_out_data.drive       <= r_res_drive;
                    r_out_data.clamped     <= r_res_clamp;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
